>>> rtl/fnvst_pkg.sv
`timescale 1ns / 1ps

package fnvst_pkg;

    // Hash and payload widths fixed by the item format
    localparam int HASH_W  = 64;
    localparam int CHAR_W  = 8;
    localparam int VAL_W   = 15;
    localparam int STAT_W  = 3;
    localparam int LIMIT_W = 8;
    localparam int COUNT_W = 9;

    localparam logic [HASH_W-1:0]  HASH_BASIS  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_REM,
        S_READ,
        S_CMP,
        S_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    byte_acc;
        logic    rem_start;
        logic    probe_init;
        logic    probe_step;
        logic    clr_step;
        logic    mem_rd;
        logic    mem_wr;
        logic    wr_clear;
        logic    cnt_inc;
        logic    res_load;
        status_t res_code;
        logic    res_hit;
        logic    out_load;
        logic    key_clear;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic too_long;
        logic rem_done;
        logic used;
        logic match;
        logic probe_last;
        logic at_limit;
        logic kind;
    } sts_t;

    // One FNV-1a step: xor the byte in, multiply by the prime 2^40 + 0x1B3
    // written as a sum of shifted copies
    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                  input logic [CHAR_W-1:0] c);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-CHAR_W){1'b0}}, c};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

>>> rtl/fnv_hashed_symbol_table.sv
`timescale 1ns / 1ps
// After the last key byte the controller checks the length, then finds the home slot and
// probes slots in turn, one memory read and one compare each, before the result is offered;
// a key that is too long goes straight to the result. When TABLE_SLOTS is not a power
// of two the home slot comes from a byte-wise remainder. Throughput: 1 byte per cycle
// within a key, one key at a time; a result left waiting holds back the next one.
// Reset is synchronous, active low; a clearing pass over every slot follows.
module fnv_hashed_symbol_table #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // key byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_char[7:0], new_value[22:8], zero[23]
    input  logic        s_tuser,   // kind
    input  logic        s_tlast,   // key_last
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[2:0], found_value[17:3], zero[23:18]
    // load limit register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    fnvst_pkg::cmd_t              cmd;
    fnvst_pkg::sts_t              sts;
    logic [fnvst_pkg::STAT_W-1:0] m_status;
    logic [fnvst_pkg::VAL_W-1:0]  m_value;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {6'b0, m_value, m_status};

    fnvst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    fnvst_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_kind    (s_tuser),
        .s_char    (s_tdata[7:0]),
        .s_value   (s_tdata[22:8]),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_limit (cfg_data),
        .m_status  (m_status),
        .m_value   (m_value)
    );

endmodule

>>> rtl/fnvst_mod.sv
`timescale 1ns / 1ps

// Home slot unit: hash modulo the slot count
module fnvst_mod #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [fnvst_pkg::HASH_W-1:0]      hash,
    output logic                              done,
    output logic [$clog2(TABLE_SLOTS)-1:0]    rem
);

    localparam int  IDX_W    = $clog2(TABLE_SLOTS);
    localparam bit  IS_POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

    logic [IDX_W-1:0] rem_reg;
    logic             done_reg;

    assign rem  = rem_reg;
    assign done = done_reg;

    if (IS_POW2) begin : g_mask
        // power of two: the low bits are the remainder
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                done_reg <= 1'b0;
            end else begin
                done_reg <= start;
            end
            if (start) begin
                rem_reg <= hash[IDX_W-1:0];
            end
        end
    end else begin : g_recip
        // byte-wise residue, top byte first: r = (r * 256 + byte) mod N.
        // The quotient comes from a reciprocal multiply and is at most one short,
        // so one compare and subtract finishes each byte, after a multiply phase.
        localparam int T_W   = IDX_W + 8;
        localparam int RCP_W = 9;
        localparam int P_W   = T_W + RCP_W;
        localparam int NQ_W  = RCP_W + IDX_W;
        localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << T_W) / 64'(TABLE_SLOTS));

        logic [fnvst_pkg::HASH_W-1:0] sh_reg;
        logic [2:0]                   bcnt_reg;
        logic                         busy_reg;
        logic                         phase_reg;
        logic [T_W-1:0]               t_reg;
        logic [P_W-1:0]               prod_reg;
        logic [T_W-1:0]               t_cur;
        logic [NQ_W-1:0]              diff;
        logic [IDX_W-1:0]             rem_next;

        always_comb begin
            t_cur = {rem_reg, sh_reg[fnvst_pkg::HASH_W-1 -: 8]};
            diff  = NQ_W'(t_reg)
                    - NQ_W'(NQ_W'(prod_reg[P_W-1 -: RCP_W]) * NQ_W'(TABLE_SLOTS));
            if (diff >= NQ_W'(TABLE_SLOTS)) begin
                rem_next = IDX_W'(diff - NQ_W'(TABLE_SLOTS));
            end else begin
                rem_next = IDX_W'(diff);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                busy_reg  <= 1'b0;
                phase_reg <= 1'b0;
                done_reg  <= 1'b0;
                bcnt_reg  <= '0;
            end else begin
                done_reg <= 1'b0;
                if (start) begin
                    busy_reg  <= 1'b1;
                    phase_reg <= 1'b0;
                    bcnt_reg  <= '0;
                end else if (busy_reg) begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        bcnt_reg <= bcnt_reg + 1'b1;
                        if (bcnt_reg == 3'(fnvst_pkg::HASH_W / 8 - 1)) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end
            if (start) begin
                sh_reg  <= hash;
                rem_reg <= '0;
            end else if (busy_reg) begin
                if (!phase_reg) begin
                    t_reg    <= t_cur;
                    prod_reg <= P_W'(t_cur) * P_W'(RCP);
                end else begin
                    sh_reg  <= sh_reg << 8;
                    rem_reg <= rem_next;
                end
            end
        end
    end

endmodule

>>> rtl/fnvst_dp.sv
`timescale 1ns / 1ps

// Datapath: key fold, slot memory, probe pointer, counters, result registers
module fnvst_dp #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fnvst_pkg::cmd_t                    cmd,
    output fnvst_pkg::sts_t                    sts,
    input  logic                               s_kind,
    input  logic [fnvst_pkg::CHAR_W-1:0]       s_char,
    input  logic [fnvst_pkg::VAL_W-1:0]        s_value,
    input  logic                               cfg_wr,
    input  logic [fnvst_pkg::LIMIT_W-1:0]      cfg_limit,
    output logic [fnvst_pkg::STAT_W-1:0]       m_status,
    output logic [fnvst_pkg::VAL_W-1:0]        m_value
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int LEN_W = $clog2(KEY_BYTES + 2);
    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int ENT_W = 1 + KEY_W + fnvst_pkg::VAL_W;

    // key accumulation
    logic [fnvst_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [KEY_W-1:0]             key_reg, key_next;
    logic [LEN_W-1:0]             len_reg, len_next;
    logic                         kind_reg;
    logic [fnvst_pkg::VAL_W-1:0]  val_reg;

    // table and probe
    logic [ENT_W-1:0]             mem_q [TABLE_SLOTS];
    logic [ENT_W-1:0]             rd_reg;
    logic [ENT_W-1:0]             wr_data;
    logic [IDX_W-1:0]             idx_reg, idx_inc;
    logic [IDX_W-1:0]             pcnt_reg;
    logic [fnvst_pkg::COUNT_W-1:0] cnt_reg;
    logic [fnvst_pkg::LIMIT_W-1:0] limit_reg;

    // result
    logic [fnvst_pkg::STAT_W-1:0] res_status_reg;
    logic [fnvst_pkg::VAL_W-1:0]  res_value_reg;
    logic [fnvst_pkg::STAT_W-1:0] out_status_reg;
    logic [fnvst_pkg::VAL_W-1:0]  out_value_reg;

    logic                         rem_done;
    logic [IDX_W-1:0]             rem;

    fnvst_mod #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.rem_start),
        .hash    (hash_reg),
        .done    (rem_done),
        .rem     (rem)
    );

    // fold one byte; zero bytes are skipped, overflow pins the length
    always_comb begin
        hash_next = hash_reg;
        key_next  = key_reg;
        len_next  = len_reg;
        if (cmd.key_clear) begin
            hash_next = fnvst_pkg::HASH_BASIS;
            key_next  = '0;
            len_next  = '0;
        end else if (cmd.byte_acc && s_char != '0) begin
            if (len_reg < LEN_W'(KEY_BYTES)) begin
                hash_next = fnvst_pkg::fnv_fold(hash_reg, s_char);
                for (int b = 0; b < KEY_BYTES; b++) begin
                    if (len_reg == LEN_W'(b)) begin
                        key_next[8*b +: 8] = s_char;
                    end
                end
                len_next = len_reg + 1'b1;
            end else begin
                len_next = LEN_W'(KEY_BYTES + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= fnvst_pkg::HASH_BASIS;
            key_reg  <= '0;
            len_reg  <= '0;
        end else begin
            hash_reg <= hash_next;
            key_reg  <= key_next;
            len_reg  <= len_next;
        end
        if (cmd.byte_acc) begin
            kind_reg <= s_kind;
            val_reg  <= s_value;
        end
    end

    // slot memory: used mark, key word, value
    assign wr_data = cmd.wr_clear ? '0 : {1'b1, key_reg, val_reg};

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem_q[idx_reg] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_reg <= mem_q[idx_reg];
        end
    end

    // slot pointer with wraparound, shared by clearing pass and probe
    assign idx_inc = (idx_reg == IDX_W'(TABLE_SLOTS - 1)) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            pcnt_reg <= '0;
        end else if (cmd.probe_init) begin
            idx_reg  <= rem;
            pcnt_reg <= '0;
        end else if (cmd.probe_step) begin
            idx_reg  <= idx_inc;
            pcnt_reg <= pcnt_reg + 1'b1;
        end else if (cmd.clr_step) begin
            idx_reg  <= idx_inc;
        end
    end

    // entry count and load limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            limit_reg <= fnvst_pkg::LIMIT_RESET;
        end else begin
            if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cfg_wr) begin
                limit_reg <= cfg_limit;
            end
        end
    end

    // result staging and output register
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_code;
            res_value_reg  <= cmd.res_hit ? rd_reg[fnvst_pkg::VAL_W-1:0] : '0;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign m_status = out_status_reg;
    assign m_value  = out_value_reg;

    always_comb begin
        sts.clr_last   = (idx_reg == IDX_W'(TABLE_SLOTS - 1));
        sts.too_long   = (len_reg > LEN_W'(KEY_BYTES));
        sts.rem_done   = rem_done;
        sts.used       = rd_reg[ENT_W-1];
        sts.match      = (rd_reg[fnvst_pkg::VAL_W +: KEY_W] == key_reg);
        sts.probe_last = (pcnt_reg == IDX_W'(TABLE_SLOTS - 1));
        sts.at_limit   = (cnt_reg >= {1'b0, limit_reg});
        sts.kind       = kind_reg;
    end

    // entry count moves only on an insert
    a_cnt_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(cnt_reg)) |-> $past(cmd.cnt_inc))
        else $error("entry count changed without an insert");

endmodule

>>> rtl/fnvst_ctrl.sv
`timescale 1ns / 1ps

// Controller: clearing pass, key intake, home slot, probe loop, response
module fnvst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output fnvst_pkg::cmd_t   cmd,
    input  fnvst_pkg::sts_t   sts
);

    fnvst_pkg::state_t state_reg, state_next;
    logic              mvalid_reg, mvalid_next;
    logic              accept;

    assign s_tready = (state_reg == fnvst_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= fnvst_pkg::S_CLEAR;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = fnvst_pkg::ST_FOUND;
        mvalid_next  = mvalid_reg && !m_tready;

        unique case (state_reg)
            fnvst_pkg::S_CLEAR: begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_clear = 1'b1;
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = fnvst_pkg::S_IDLE;
                end
            end
            fnvst_pkg::S_IDLE: begin
                cmd.byte_acc = accept;
                if (accept && s_tlast) begin
                    state_next = fnvst_pkg::S_CHECK;
                end
            end
            fnvst_pkg::S_CHECK: begin
                if (sts.too_long) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = fnvst_pkg::ST_TOO_LONG;
                    state_next   = fnvst_pkg::S_RESP;
                end else begin
                    cmd.rem_start = 1'b1;
                    state_next    = fnvst_pkg::S_REM;
                end
            end
            fnvst_pkg::S_REM: begin
                if (sts.rem_done) begin
                    cmd.probe_init = 1'b1;
                    state_next     = fnvst_pkg::S_READ;
                end
            end
            fnvst_pkg::S_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = fnvst_pkg::S_CMP;
            end
            fnvst_pkg::S_CMP: begin
                state_next = fnvst_pkg::S_RESP;
                if (!sts.used) begin
                    // empty slot: miss, full at the limit, or insert here
                    cmd.res_load = 1'b1;
                    if (!sts.kind) begin
                        cmd.res_code = fnvst_pkg::ST_MISS;
                    end else if (sts.at_limit) begin
                        cmd.res_code = fnvst_pkg::ST_FULL;
                    end else begin
                        cmd.mem_wr   = 1'b1;
                        cmd.cnt_inc  = 1'b1;
                        cmd.res_code = fnvst_pkg::ST_INSERTED;
                    end
                end else if (sts.match) begin
                    // hit: read out or overwrite value
                    cmd.res_load = 1'b1;
                    cmd.res_code = fnvst_pkg::ST_FOUND;
                    cmd.res_hit  = !sts.kind;
                    cmd.mem_wr   = sts.kind;
                end else if (sts.probe_last) begin
                    // whole table visited, no room
                    cmd.res_load = 1'b1;
                    cmd.res_code = sts.kind ? fnvst_pkg::ST_FULL : fnvst_pkg::ST_MISS;
                end else begin
                    cmd.probe_step = 1'b1;
                    state_next     = fnvst_pkg::S_READ;
                end
            end
            fnvst_pkg::S_RESP: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    cmd.key_clear = 1'b1;
                    mvalid_next   = 1'b1;
                    state_next    = fnvst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fnvst_pkg::S_IDLE;
            end
        endcase
    end

    a_clear_no_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fnvst_pkg::S_CLEAR) |-> !s_tready)
        else $error("input taken during clearing pass");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> (state_reg == fnvst_pkg::S_CLEAR || state_reg == fnvst_pkg::S_CMP))
        else $error("slot write outside clearing or compare");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mvalid_reg) |-> $past(state_reg == fnvst_pkg::S_RESP))
        else $error("result raised outside response state");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS       = 256;
    localparam int KEY_MAX     = 8;
    localparam logic [63:0] HASH_MULT = 64'd1099511628211;
    localparam int ITEM_GOAL   = 1200;
    localparam int ITEM_CAP    = 1800;
    localparam int HOLD_CYCLES = 500;
    localparam int HOLD_AFTER  = 200;   // results seen before the long hold-off

    // One expected result transaction
    typedef struct packed {
        fnvst_pkg::status_t status;
        logic [14:0]        value;
    } reply_t;

    // Key as sent: length in bytes, first byte in the low bits
    typedef struct packed {
        logic [3:0]  len;
        logic [79:0] bytes;
    } key_t;

    // Directed stimulus: one key byte per row, pinned result on the last byte
    typedef struct packed {
        logic               kind;
        logic [7:0]         ch;
        logic               is_last;
        logic [14:0]        val;
        logic               pin;
        fnvst_pkg::status_t st;
        logic [14:0]        fv;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // empty key: miss, insert, hit
        '{1'b0, 8'h00, 1'b1, 15'h0000, 1'b1, fnvst_pkg::ST_MISS,     15'h0000},
        '{1'b1, 8'h00, 1'b1, 15'h7FFF, 1'b1, fnvst_pkg::ST_INSERTED, 15'h0000},
        '{1'b0, 8'h00, 1'b1, 15'h0000, 1'b1, fnvst_pkg::ST_FOUND,    15'h7FFF},
        // single top byte, value zero
        '{1'b1, 8'hFF, 1'b1, 15'h0000, 1'b1, fnvst_pkg::ST_INSERTED, 15'h0000},
        // zero byte inside a key is skipped; kind only counts on the last byte
        '{1'b1, 8'h01, 1'b0, 15'h7FFF, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b1, 8'h00, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b0, 8'h02, 1'b1, 15'h0000, 1'b1, fnvst_pkg::ST_MISS,     15'h0000},
        '{1'b0, 8'h01, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b1, 8'h02, 1'b1, 15'h1234, 1'b1, fnvst_pkg::ST_INSERTED, 15'h0000},
        // update through the same key with a zero byte in it
        '{1'b0, 8'h01, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b0, 8'h00, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b1, 8'h02, 1'b1, 15'h5555, 1'b1, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b1, 8'h01, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b0, 8'h02, 1'b1, 15'h0000, 1'b1, fnvst_pkg::ST_FOUND,    15'h5555},
        // nine bytes: too long, table left alone
        '{1'b0, 8'h80, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b1, 8'h40, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b0, 8'h20, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b1, 8'h10, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b0, 8'h08, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b1, 8'h04, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b0, 8'h02, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b1, 8'h01, 1'b0, 15'h0000, 1'b0, fnvst_pkg::ST_FOUND,    15'h0000},
        '{1'b1, 8'hFF, 1'b1, 15'h2AAA, 1'b1, fnvst_pkg::ST_TOO_LONG, 15'h0000}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // key_char[7:0], new_value[22:8], zero[23]
    logic        s_tuser;   // kind
    logic        s_tlast;   // key_last
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // status[2:0], found_value[17:3], zero[23:18]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    // Pinned expectation travelling with the byte on offer
    logic               pin_on;
    fnvst_pkg::status_t pin_status;
    logic [14:0]        pin_value;

    // Predictor state
    logic [63:0] hash_acc;
    logic [63:0] key_word;
    int          key_len;
    logic [63:0] slot_key [SLOTS];
    logic [14:0] slot_val [SLOTS];
    bit          slot_used [SLOTS];
    int          n_entries;
    int          lim;

    reply_t replies_due [$];
    key_t   seen_keys [$];
    int     errors;
    int     items_sent;
    int     results_seen;
    int     burst_left;

    fnv_hashed_symbol_table #(
        .TABLE_SLOTS (SLOTS),
        .KEY_BYTES   (KEY_MAX)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Fold one key byte into the hash and key word; on the last byte run the
    // table operation and return its result
    function automatic bit fold_key_byte(input logic kind, input logic [7:0] ch,
                                         input logic is_last, input logic [14:0] val,
                                         output reply_t r);
        int  idx;
        int  n;
        bit  hit;
        bit  room;
        r    = '{fnvst_pkg::ST_FOUND, 15'h0000};
        hit  = 1'b0;
        room = 1'b0;
        if (ch != 8'h00) begin
            if (key_len < KEY_MAX) begin
                hash_acc = (hash_acc ^ {56'h0, ch}) * HASH_MULT;
                key_word = key_word | ({56'h0, ch} << (8 * key_len));
                key_len++;
            end else begin
                key_len = KEY_MAX + 1;
            end
        end
        if (!is_last)
            return 1'b0;

        if (key_len > KEY_MAX) begin
            r.status = fnvst_pkg::ST_TOO_LONG;
        end else begin
            // linear probe from the home slot, wrapping round
            idx = int'(hash_acc % SLOTS);
            for (n = 0; n < SLOTS; n++) begin
                if (!slot_used[idx]) begin
                    room = 1'b1;
                    break;
                end
                if (slot_key[idx] == key_word) begin
                    hit = 1'b1;
                    break;
                end
                idx = (idx + 1) % SLOTS;
            end
            if (hit) begin
                if (kind)
                    slot_val[idx] = val;
                else
                    r.value = slot_val[idx];
                r.status = fnvst_pkg::ST_FOUND;
            end else if (!kind) begin
                r.status = fnvst_pkg::ST_MISS;
            end else if (!room || n_entries >= lim) begin
                r.status = fnvst_pkg::ST_FULL;
            end else begin
                slot_used[idx] = 1'b1;
                slot_key[idx]  = key_word;
                slot_val[idx]  = val;
                n_entries      = (n_entries + 1) % 512;
                r.status       = fnvst_pkg::ST_INSERTED;
            end
        end
        hash_acc = fnvst_pkg::HASH_BASIS;
        key_word = '0;
        key_len  = 0;
        return 1'b1;
    endfunction

    // Scoreboard: predict on every accepted byte, check every result
    always @(posedge aclk) begin : scoreboard
        reply_t      want;
        reply_t      pred;
        logic [2:0]  got_st;
        logic [14:0] got_fv;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                lim = int'(cfg_data);
            if (s_tvalid && s_tready) begin
                if (fold_key_byte(s_tuser, s_tdata[7:0], s_tlast, s_tdata[22:8], pred))
                    replies_due.push_back(pin_on ? reply_t'{pin_status, pin_value} : pred);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_st = m_tdata[2:0];
                got_fv = m_tdata[17:3];
                if (replies_due.size() == 0) begin
                    $error("unexpected result: status %0d found_value %0d", got_st, got_fv);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    if (got_st != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got_st);
                        errors++;
                    end
                    if (got_fv != want.value) begin
                        $error("found_value: expected %0d, got %0d", want.value, got_fv);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver: segments of differing readiness, plus one long hold-off
    initial begin : receiver
        int  mode;
        int  seg_left;
        bit  held;
        m_tready <= 1'b0;
        seg_left = 0;
        mode     = 0;
        held     = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 60);
                end
                seg_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one byte and wait for its transaction; gaps fall between bursts
    task automatic offer_byte(input logic kind, input logic [7:0] ch, input logic is_last,
                              input logic [14:0] val, input logic pin,
                              input fnvst_pkg::status_t pst, input logic [14:0] pfv);
        s_tvalid   <= 1'b1;
        s_tdata    <= {1'b0, val, ch};
        s_tuser    <= kind;
        s_tlast    <= is_last;
        pin_on     <= pin;
        pin_status <= pst;
        pin_value  <= pfv;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    function automatic logic [14:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 15'h0000;
        if (r < 10)
            return 15'h7FFF;
        return 15'($urandom_range(0, 32767));
    endfunction

    // New key: mostly short, a few empty and a few over length
    function automatic key_t fresh_key();
        key_t k;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 3)
            k.len = 4'd0;
        else if (r < 10)
            k.len = 4'($urandom_range(9, 10));
        else if (r < 65)
            k.len = 4'($urandom_range(1, 2));
        else if (r < 90)
            k.len = 4'($urandom_range(3, 5));
        else
            k.len = 4'($urandom_range(6, 8));
        for (int i = 0; i < 10; i++)
            k.bytes[8*i +: 8] = 8'($urandom_range(1, 255));
        return k;
    endfunction

    // Send a whole key, with stray zero bytes now and then
    task automatic send_key(input key_t k, input logic do_store, input logic [14:0] v);
        bit trailing;
        bit is_last;
        trailing = (k.len == 0) || ($urandom_range(0, 19) == 0);
        for (int i = 0; i < int'(k.len); i++) begin
            if ($urandom_range(0, 19) == 0)
                offer_byte(1'($urandom_range(0, 1)), 8'h00, 1'b0, pick_value(),
                           1'b0, fnvst_pkg::ST_FOUND, 15'h0000);
            is_last = !trailing && (i == int'(k.len) - 1);
            offer_byte(is_last ? do_store : 1'($urandom_range(0, 1)), k.bytes[8*i +: 8],
                       is_last, is_last ? v : pick_value(), 1'b0, fnvst_pkg::ST_FOUND,
                       15'h0000);
        end
        if (trailing)
            offer_byte(do_store, 8'h00, 1'b1, v, 1'b0, fnvst_pkg::ST_FOUND, 15'h0000);
    endtask

    // Random keys: a share of new ones, the rest drawn from keys already sent
    task automatic run_keys(input int item_goal, input bit until_full,
                            input int fresh_pct, input int store_pct);
        key_t k;
        while ((items_sent < item_goal || (until_full && n_entries < SLOTS - 1))
               && items_sent < ITEM_CAP) begin
            if (seen_keys.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
                k = fresh_key();
                seen_keys.push_back(k);
            end else begin
                k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
            end
            send_key(k, $urandom_range(0, 99) < store_pct, pick_value());
        end
        s_tvalid <= 1'b0;
    endtask

    // Write the load limit once every result is back and the probe has settled
    task automatic set_load_limit(input logic [7:0] v);
        @(posedge aclk);
        while (replies_due.size() != 0 || !s_tready) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial begin : stimulus
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= 1'b0;
        s_tlast    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        pin_on     <= 1'b0;
        pin_status <= fnvst_pkg::ST_FOUND;
        pin_value  <= '0;
        hash_acc     = fnvst_pkg::HASH_BASIS;
        key_word     = '0;
        key_len      = 0;
        n_entries    = 0;
        lim          = int'(fnvst_pkg::LIMIT_RESET);
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        burst_left   = $urandom_range(1, 12);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part under the reset limit
        for (int i = 0; i < DIR_ROWS; i++)
            offer_byte(DIR_TABLE[i].kind, DIR_TABLE[i].ch, DIR_TABLE[i].is_last,
                       DIR_TABLE[i].val, DIR_TABLE[i].pin, DIR_TABLE[i].st, DIR_TABLE[i].fv);
        s_tvalid <= 1'b0;

        // lowest limit: every new key refused
        set_load_limit(8'd1);
        run_keys(items_sent + 80, 1'b0, 50, 60);

        // somewhere in between
        set_load_limit(8'($urandom_range(2, 254)));
        run_keys(items_sent + 300, 1'b0, 50, 60);

        // highest limit: fill the table to the limit and beyond
        set_load_limit(8'd255);
        run_keys(ITEM_GOAL, 1'b1, 95, 95);

        @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #100_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/fnvst_pkg.sv
rtl/fnvst_mod.sv
rtl/fnvst_dp.sv
rtl/fnvst_ctrl.sv
rtl/fnv_hashed_symbol_table.sv
sim/tb.sv
